// ===== hw/rtl/deadline_timer_queue_defines.svh =====
// Assertion macros used by the deadline timer queue top level.
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DTQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dtq_pkg.sv =====
// Shared types and constants for the deadline timer queue.
package dtq_pkg;

  localparam int ID_BITS      = 8;
  localparam int TIMEOUT_BITS = 24;
  localparam int DELAY_BITS   = 24;
  localparam int SEQ_BITS     = 64;
  localparam int MAX_EXPIRE   = 32;
  localparam int EXP_CNT_BITS = 6;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [ID_BITS-1:0]      id_t;
  typedef logic [EXP_CNT_BITS-1:0] exp_cnt_t;

  typedef enum logic [1:0] {
    MODE_ARM     = 2'd0,
    MODE_ADJUST  = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_POP     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_REPORT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_REMOVE = 2'd1,
    CELL_INSERT = 2'd2
  } cell_op_t;

  // Command broadcast to every cell of the sorted chain.
  typedef struct packed {
    cell_op_t op;
    id_t      match_id;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/dtq_cell.sv =====
// One cell of the sorted timer chain: holds a single timer and trades it with its neighbors.
module dtq_cell #(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dtq_pkg::cell_ctl_t     ctl,
  input  logic [TIME_BITS-1:0]   key_dl,
  input  dtq_pkg::seq_t          key_seq,
  input  logic                   flag_in,
  input  logic                   lft_vld,
  input  dtq_pkg::id_t           lft_id,
  input  logic [TIME_BITS-1:0]   lft_dl,
  input  dtq_pkg::seq_t          lft_seq,
  input  logic                   rgt_vld,
  input  dtq_pkg::id_t           rgt_id,
  input  logic [TIME_BITS-1:0]   rgt_dl,
  input  dtq_pkg::seq_t          rgt_seq,
  output logic                   flag_out,
  output logic                   vld,
  output dtq_pkg::id_t           id,
  output logic [TIME_BITS-1:0]   dl,
  output dtq_pkg::seq_t          seq,
  output dtq_pkg::seq_t          hit_seq
);

  logic                 vld_r, vld_nxt;
  dtq_pkg::id_t         id_r, id_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  dtq_pkg::seq_t        seq_r, seq_nxt;
  logic [TIME_BITS-1:0] diff;
  logic                 hit;
  logic                 key_first;

  // The key goes ahead of this entry when the entry is empty, when its deadline is
  // earlier by wrapped difference, or when deadlines tie and it was armed first.
  assign diff      = key_dl - dl_r;
  assign hit       = vld_r && (id_r == ctl.match_id);
  assign key_first = !vld_r || ((diff == '0) ? (key_seq < seq_r) : diff[TIME_BITS-1]);
  assign hit_seq   = hit ? seq_r : '0;

  always_comb begin
    vld_nxt  = vld_r;
    id_nxt   = id_r;
    dl_nxt   = dl_r;
    seq_nxt  = seq_r;
    flag_out = flag_in;
    unique case (ctl.op)
      dtq_pkg::CELL_HOLD: begin
        flag_out = flag_in;
      end
      dtq_pkg::CELL_REMOVE: begin
        flag_out = flag_in | hit;
        if (flag_out) begin
          vld_nxt = rgt_vld;
          id_nxt  = rgt_id;
          dl_nxt  = rgt_dl;
          seq_nxt = rgt_seq;
        end
      end
      dtq_pkg::CELL_INSERT: begin
        flag_out = flag_in | key_first;
        if (flag_in) begin
          vld_nxt = lft_vld;
          id_nxt  = lft_id;
          dl_nxt  = lft_dl;
          seq_nxt = lft_seq;
        end else if (key_first) begin
          vld_nxt = 1'b1;
          id_nxt  = ctl.match_id;
          dl_nxt  = key_dl;
          seq_nxt = key_seq;
        end
      end
      default: begin
        flag_out = flag_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    dl_r  <= dl_nxt;
    seq_r <= seq_nxt;
  end

  assign vld = vld_r;
  assign id  = id_r;
  assign dl  = dl_r;
  assign seq = seq_r;

endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: command sequencer around a sorted chain of timer cells.
//
//   Channel   Ports                                         Handshake
//   --------  --------------------------------------------  ---------------------------------
//   command   in_mode in_timer_id in_timeout_ms             taken when start=1 and busy=0
//             in_elapsed_ms
//   result    out_kind out_timer_id_res out_status          each shown for one cycle, out_valid=1
//             out_delay_ms out_queue_empty out_last
//
// Arm and adjust pass through lookup, insert and then the result register; arm or adjust
// that is refused and pop pass through lookup and the result register. Advance removes
// expired timers from the head one per step, at most 32 (MAX_EXPIRE), then gives the
// closing report, then the result register.
// Reset is synchronous and active low; it empties the chain and zeroes the time base.
// The receiver cannot stall: every result is shown for exactly one cycle.
`include "deadline_timer_queue_defines.svh"

module deadline_timer_queue #(
  parameter int CAPACITY  = 32,
  parameter int ID_COUNT  = 256,
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_mode,
  input  logic [dtq_pkg::ID_BITS-1:0]         in_timer_id,
  input  logic [dtq_pkg::TIMEOUT_BITS-1:0]    in_timeout_ms,
  input  logic [dtq_pkg::TIMEOUT_BITS-1:0]    in_elapsed_ms,
  output logic                                out_valid,
  output logic [1:0]                          out_kind,
  output logic [dtq_pkg::ID_BITS-1:0]         out_timer_id_res,
  output logic [1:0]                          out_status,
  output logic [dtq_pkg::DELAY_BITS-1:0]      out_delay_ms,
  output logic                                out_queue_empty,
  output logic                                out_last
);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_EXPIRE = 4'b1000
  } state_t;

  // The chain keeps timers sorted, earliest in cell 0. Index CAPACITY is a constant
  // empty slot past the tail, so the last cell shifts in an empty entry on removal.
  logic               vld     [CAPACITY+1];
  dtq_pkg::id_t       ent_id  [CAPACITY+1];
  time_t              ent_dl  [CAPACITY+1];
  dtq_pkg::seq_t      ent_seq [CAPACITY+1];
  logic               flag    [CAPACITY+1];
  dtq_pkg::seq_t      hit_seq [CAPACITY];

  dtq_pkg::cell_ctl_t cell_ctl;
  logic               flag_head;

  state_t             state_r, state_nxt;
  dtq_pkg::mode_t     mode_r, mode_nxt;
  dtq_pkg::id_t       key_id_r, key_id_nxt;
  logic               in_range_r, in_range_nxt;
  time_t              key_dl_r, key_dl_nxt;
  dtq_pkg::seq_t      key_seq_r, key_seq_nxt;
  time_t              now_r, now_nxt;
  dtq_pkg::seq_t      arm_cnt_r, arm_cnt_nxt;
  dtq_pkg::exp_cnt_t  exp_cnt_r, exp_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  dtq_pkg::kind_t     out_kind_r, out_kind_nxt;
  dtq_pkg::id_t       out_id_r, out_id_nxt;
  dtq_pkg::status_t   out_status_r, out_status_nxt;
  logic [dtq_pkg::DELAY_BITS-1:0] out_delay_r, out_delay_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic               out_last_r, out_last_nxt;

  dtq_pkg::seq_t      found_seq;
  logic               known;
  logic               full;
  time_t              head_diff;
  logic               expire_now;
  logic [dtq_pkg::DELAY_BITS-1:0] report_delay;
  logic               res_expired;

  assign vld[CAPACITY]     = 1'b0;
  assign ent_id[CAPACITY]  = '0;
  assign ent_dl[CAPACITY]  = '0;
  assign ent_seq[CAPACITY] = '0;
  assign flag[0]           = flag_head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      dtq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .key_dl   (key_dl_r),
        .key_seq  (key_seq_r),
        .flag_in  (flag[i]),
        .lft_vld  (1'b0),
        .lft_id   ('0),
        .lft_dl   ('0),
        .lft_seq  ('0),
        .rgt_vld  (vld[i+1]),
        .rgt_id   (ent_id[i+1]),
        .rgt_dl   (ent_dl[i+1]),
        .rgt_seq  (ent_seq[i+1]),
        .flag_out (flag[i+1]),
        .vld      (vld[i]),
        .id       (ent_id[i]),
        .dl       (ent_dl[i]),
        .seq      (ent_seq[i]),
        .hit_seq  (hit_seq[i])
      );
    end else begin : g_body
      dtq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .key_dl   (key_dl_r),
        .key_seq  (key_seq_r),
        .flag_in  (flag[i]),
        .lft_vld  (vld[i-1]),
        .lft_id   (ent_id[i-1]),
        .lft_dl   (ent_dl[i-1]),
        .lft_seq  (ent_seq[i-1]),
        .rgt_vld  (vld[i+1]),
        .rgt_id   (ent_id[i+1]),
        .rgt_dl   (ent_dl[i+1]),
        .rgt_seq  (ent_seq[i+1]),
        .flag_out (flag[i+1]),
        .vld      (vld[i]),
        .id       (ent_id[i]),
        .dl       (ent_dl[i]),
        .seq      (ent_seq[i]),
        .hit_seq  (hit_seq[i])
      );
    end
  end

  // At most one cell matches an id, so an OR over the masked sequence numbers picks
  // out the arming order of the matched timer.
  always_comb begin
    found_seq = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_seq = found_seq | hit_seq[i];
    end
  end

  // During lookup the removal flag reaching the tail says whether the id was found.
  assign known = flag[CAPACITY];
  assign full  = vld[CAPACITY-1];

  // A timer is due when its deadline lies strictly before the current time, judged
  // by the sign of the wrapped difference.
  assign head_diff  = ent_dl[0] - now_r;
  assign expire_now = vld[0] && head_diff[TIME_BITS-1] &&
                      (exp_cnt_r < dtq_pkg::exp_cnt_t'(dtq_pkg::MAX_EXPIRE));

  always_comb begin
    if (head_diff[TIME_BITS-1]) begin
      report_delay = '0;
    end else if (head_diff[TIME_BITS-2:dtq_pkg::DELAY_BITS] != '0) begin
      report_delay = dtq_pkg::DELAY_MAX;
    end else begin
      report_delay = head_diff[dtq_pkg::DELAY_BITS-1:0];
    end
  end

  // Chain command for the current step.
  always_comb begin
    cell_ctl.op       = dtq_pkg::CELL_HOLD;
    cell_ctl.match_id = key_id_r;
    flag_head         = 1'b0;
    unique case (state_r)
      ST_LOOKUP: begin
        if (mode_r == dtq_pkg::MODE_POP) begin
          cell_ctl.op = dtq_pkg::CELL_REMOVE;
          flag_head   = vld[0];
        end else if (in_range_r) begin
          // Removing by id is harmless when the id is absent: no cell shifts.
          cell_ctl.op = dtq_pkg::CELL_REMOVE;
        end
      end
      ST_INSERT: begin
        cell_ctl.op = dtq_pkg::CELL_INSERT;
      end
      ST_EXPIRE: begin
        if (expire_now) begin
          cell_ctl.op = dtq_pkg::CELL_REMOVE;
          flag_head   = 1'b1;
        end
      end
      ST_IDLE: begin
        cell_ctl.op = dtq_pkg::CELL_HOLD;
      end
      default: begin
        cell_ctl.op = dtq_pkg::CELL_HOLD;
      end
    endcase
  end

  // Sequencer: next values of all control and result registers.
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_id_nxt     = key_id_r;
    in_range_nxt   = in_range_r;
    key_dl_nxt     = key_dl_r;
    key_seq_nxt    = key_seq_r;
    now_nxt        = now_r;
    arm_cnt_nxt    = arm_cnt_r;
    exp_cnt_nxt    = exp_cnt_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_delay_nxt  = out_delay_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt     = dtq_pkg::mode_t'(in_mode);
          key_id_nxt   = in_timer_id;
          in_range_nxt = int'(in_timer_id) < ID_COUNT;
          if (dtq_pkg::mode_t'(in_mode) == dtq_pkg::MODE_ADVANCE) begin
            now_nxt     = now_r + time_t'(in_elapsed_ms);
            exp_cnt_nxt = '0;
            state_nxt   = ST_EXPIRE;
          end else begin
            key_dl_nxt = now_r + time_t'(in_timeout_ms);
            state_nxt  = ST_LOOKUP;
          end
        end
      end

      ST_LOOKUP: begin
        // Default answer is a single acknowledge; an insert step defers it.
        out_kind_nxt   = dtq_pkg::KIND_ACK;
        out_id_nxt     = '0;
        out_delay_nxt  = '0;
        out_empty_nxt  = 1'b0;
        out_last_nxt   = 1'b1;
        out_status_nxt = dtq_pkg::STATUS_OK;
        state_nxt      = ST_IDLE;
        if (mode_r == dtq_pkg::MODE_POP) begin
          out_valid_nxt = 1'b1;
          if (!vld[0]) begin
            out_status_nxt = dtq_pkg::STATUS_ABSENT;
          end
        end else if (in_range_r && known) begin
          // Rearm counts as newly armed; adjust keeps the old arming order.
          if (mode_r == dtq_pkg::MODE_ARM) begin
            key_seq_nxt = arm_cnt_r;
            arm_cnt_nxt = arm_cnt_r + dtq_pkg::seq_t'(1);
          end else begin
            key_seq_nxt = found_seq;
          end
          state_nxt = ST_INSERT;
        end else if ((mode_r != dtq_pkg::MODE_ARM) || !in_range_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dtq_pkg::STATUS_ABSENT;
        end else if (full) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dtq_pkg::STATUS_FULL;
        end else begin
          key_seq_nxt = arm_cnt_r;
          arm_cnt_nxt = arm_cnt_r + dtq_pkg::seq_t'(1);
          state_nxt   = ST_INSERT;
        end
      end

      ST_INSERT: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = dtq_pkg::KIND_ACK;
        out_id_nxt     = '0;
        out_status_nxt = dtq_pkg::STATUS_OK;
        out_delay_nxt  = '0;
        out_empty_nxt  = 1'b0;
        out_last_nxt   = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_EXPIRE: begin
        out_valid_nxt  = 1'b1;
        out_id_nxt     = '0;
        out_status_nxt = dtq_pkg::STATUS_OK;
        out_delay_nxt  = '0;
        out_empty_nxt  = 1'b0;
        if (expire_now) begin
          // The head leaves the chain in this same cycle.
          out_kind_nxt = dtq_pkg::KIND_EXPIRED;
          out_id_nxt   = ent_id[0];
          out_last_nxt = 1'b0;
          exp_cnt_nxt  = exp_cnt_r + dtq_pkg::exp_cnt_t'(1);
        end else begin
          out_kind_nxt = dtq_pkg::KIND_REPORT;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
          if (!vld[0]) begin
            out_status_nxt = dtq_pkg::STATUS_ABSENT;
            out_empty_nxt  = 1'b1;
          end else begin
            out_delay_nxt = report_delay;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      arm_cnt_r   <= '0;
      exp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      arm_cnt_r   <= arm_cnt_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_id_r     <= key_id_nxt;
    in_range_r   <= in_range_nxt;
    key_dl_r     <= key_dl_nxt;
    key_seq_r    <= key_seq_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_delay_r  <= out_delay_nxt;
    out_empty_r  <= out_empty_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_timer_id_res = out_id_r;
  assign out_status       = out_status_r;
  assign out_delay_ms     = out_delay_r;
  assign out_queue_empty  = out_empty_r;
  assign out_last         = out_last_r;

  assign res_expired = out_valid && (out_kind == dtq_pkg::KIND_EXPIRED);

  // An accepted transaction keeps the block busy in the following cycle.
  `DTQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy dropped after accept")

  // Expiry results are never the final result of an advance.
  `DTQ_ASSERT_SAME(a_expired_not_last, clk, rst_n, res_expired, !out_last, "expiry marked last")

  // A result that closes a transaction leaves the sequencer idle.
  `DTQ_ASSERT_SAME(a_last_idle, clk, rst_n, out_valid && out_last, !busy, "last result while busy")

  // The chain stays packed toward the head: no hole before an occupied cell.
  for (genvar i = 1; i < CAPACITY; i++) begin : g_chk
    `DTQ_ASSERT_SAME(a_packed, clk, rst_n, vld[i], vld[i-1], "hole in timer chain")
  end

endmodule
